### rtl/apa_pkg.sv
// ----------------------------------------------------------------------------
// apa_pkg
// Shared constants, codes and types of the address pool allocator.
// ----------------------------------------------------------------------------
package apa_pkg;

	localparam int NUM_POOLS      = 4;
	localparam int POOL_SIZE      = 256;

	localparam int ADDR_FIELD_W   = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_W          = 32;

	// bitmap storage geometry
	localparam int WORD_W         = 32;
	localparam int BIT_W          = $clog2(WORD_W);
	localparam int WORDS_PER_POOL = (POOL_SIZE + WORD_W - 1) / WORD_W;
	localparam int RAM_DEPTH      = NUM_POOLS * WORDS_PER_POOL;
	localparam int ADDR_W         = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int POOL_W         = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int WIDX_W         = (WORDS_PER_POOL > 1) ? $clog2(WORDS_PER_POOL) : 1;
	localparam logic [ADDR_FIELD_W-1:0] OFF_MAX = ADDR_FIELD_W'(POOL_SIZE - 1);

	// request codes
	localparam logic [2:0] OP_GRANT_ANY  = 3'd0;
	localparam logic [2:0] OP_GRANT_POOL = 3'd1;
	localparam logic [2:0] OP_CLAIM      = 3'd2;
	localparam logic [2:0] OP_RELEASE    = 3'd3;
	localparam logic [2:0] OP_QUERY      = 3'd4;

	// result codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_DEPLETED   = 3'd1;
	localparam logic [2:0] ST_IN_USE     = 3'd2;
	localparam logic [2:0] ST_NOT_IN_USE = 3'd3;
	localparam logic [2:0] ST_NO_POOL    = 3'd4;

	typedef struct packed {
		logic [2:0]              opcode;
		logic [1:0]              pool_select;
		logic [ADDR_FIELD_W-1:0] req_address;
	} apa_req_t;

	typedef struct packed {
		logic [2:0]              status;
		logic [ADDR_FIELD_W-1:0] granted_address;
		logic                    is_free;
	} apa_rsp_t;

	typedef struct packed {
		logic                    exists;
		logic [ADDR_FIELD_W-1:0] first;
		logic [WIDX_W-1:0]       last_word;
		logic [BIT_W-1:0]        last_bit;
	} pool_info_t;

	typedef struct packed {
		logic              hit;
		logic [POOL_W-1:0] pool;
		logic [WIDX_W-1:0] word;
		logic [BIT_W-1:0]  bit_sel;
	} owner_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} ram_wr_t;

	function automatic logic [ADDR_W-1:0] ram_addr(input logic [POOL_W-1:0] p,
			input logic [WIDX_W-1:0] w);
		return ADDR_W'(ADDR_W'(p) * ADDR_W'(WORDS_PER_POOL)) + ADDR_W'(w);
	endfunction

endpackage

### rtl/address_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// address_pool_allocator_top
// Claim, release and query pass from item accept through DECODE, READ, CHECK,
// WRITE (claim and release only) and FINISH to the output register; an address in no pool goes from DECODE to FINISH.
// A grant scans the bitmap one word per read, each word through READ and CHECK,
// with a PSEL step for each pool visited, over up to four pools of 256 addresses.
// One item is in work at a time; a finished result waits in the output register.
// After reset the bitmap is cleared, all 32 rows, one row per cycle, with
// no item accepted; pool registers reset to empty ranges.
// ----------------------------------------------------------------------------
module address_pool_allocator_top
	import apa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  apa_req_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output apa_rsp_t             out_data
);

	pool_info_t [NUM_POOLS-1:0] pools;
	owner_t                  owner;
	logic [ADDR_FIELD_W-1:0] lookup_addr;
	ram_wr_t                 ram_wr;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [WORD_W-1:0]       ram_rdata;

	apa_pool_map u_pool_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.lookup_addr (lookup_addr),
		.pools       (pools),
		.owner       (owner)
	);

	apa_bitmap_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	apa_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.pools       (pools),
		.owner       (owner),
		.lookup_addr (lookup_addr),
		.ram_wr      (ram_wr),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

endmodule

### rtl/apa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// apa_bitmap_ram
// Allocation bitmap store, one word per row, one write and one registered read.
// ----------------------------------------------------------------------------
module apa_bitmap_ram
	import apa_pkg::*;
(
	input  logic              clk,
	input  ram_wr_t           wr,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/apa_pool_map.sv
// ----------------------------------------------------------------------------
// apa_pool_map
// Pool range registers, per-pool extent decode and owner lookup of an address.
// ----------------------------------------------------------------------------
module apa_pool_map
	import apa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic [ADDR_FIELD_W-1:0] lookup_addr,
	output pool_info_t [NUM_POOLS-1:0] pools,
	output owner_t                  owner
);

	logic [ADDR_FIELD_W-1:0] first_q [NUM_POOLS];
	logic [ADDR_FIELD_W-1:0] last_q  [NUM_POOLS];
	logic [ADDR_FIELD_W-1:0] max_off [NUM_POOLS];
	logic [ADDR_FIELD_W-1:0] off     [NUM_POOLS];
	logic [NUM_POOLS-1:0]    in_pool;

	for (genvar p = 0; p < NUM_POOLS; p++) begin : g_pool
		logic [ADDR_FIELD_W-1:0] diff;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				first_q[p] <= ADDR_FIELD_W'(1);
				last_q[p]  <= '0;
			end else if (cfg_we && cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(p)) begin
				if (cfg_index[0]) begin
					last_q[p] <= cfg_wdata[ADDR_FIELD_W-1:0];
				end else begin
					first_q[p] <= cfg_wdata[ADDR_FIELD_W-1:0];
				end
			end
		end

		// range is cut to the pool size
		assign diff       = last_q[p] - first_q[p];
		assign max_off[p] = (diff > OFF_MAX) ? OFF_MAX : diff;
		assign off[p]     = lookup_addr - first_q[p];

		assign pools[p].exists    = (last_q[p] >= first_q[p]);
		assign pools[p].first     = first_q[p];
		assign pools[p].last_word = WIDX_W'(max_off[p] >> BIT_W);
		assign pools[p].last_bit  = max_off[p][BIT_W-1:0];

		assign in_pool[p] = (last_q[p] >= first_q[p]) && (lookup_addr >= first_q[p]) &&
			(off[p] <= max_off[p]);
	end

	// lowest numbered pool owns the address
	always_comb begin
		owner = '0;
		for (int p = NUM_POOLS - 1; p >= 0; p--) begin
			if (in_pool[p]) begin
				owner.hit     = 1'b1;
				owner.pool    = POOL_W'(p);
				owner.word    = WIDX_W'(off[p] >> BIT_W);
				owner.bit_sel = off[p][BIT_W-1:0];
			end
		end
	end

endmodule

### rtl/apa_seq.sv
// ----------------------------------------------------------------------------
// apa_seq
// Request sequencer: bitmap clearing, first-free word scan and
// read-modify-write of single allocation bits.
// ----------------------------------------------------------------------------
module apa_seq
	import apa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  apa_req_t                in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output apa_rsp_t                out_data,
	input  pool_info_t [NUM_POOLS-1:0] pools,
	input  owner_t                  owner,
	output logic [ADDR_FIELD_W-1:0] lookup_addr,
	output ram_wr_t                 ram_wr,
	output logic [ADDR_W-1:0]       ram_raddr,
	input  logic [WORD_W-1:0]       ram_rdata
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_DECODE = 8'b0000_0100,
		S_PSEL   = 8'b0000_1000,
		S_READ   = 8'b0001_0000,
		S_CHECK  = 8'b0010_0000,
		S_WRITE  = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_q;
	apa_req_t          req_q;
	logic [POOL_W-1:0] pool_q;
	logic [WIDX_W-1:0] word_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WORD_W-1:0] wdata_q;
	apa_rsp_t          res_q;
	apa_rsp_t          out_q;
	logic              out_valid_q;

	pool_info_t        pi;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] free_bits;
	logic [BIT_W-1:0]  low_bit;
	logic              is_grant;
	logic              last_pool;
	logic              out_free;

	assign pi        = pools[pool_q];
	assign is_grant  = (req_q.opcode == OP_GRANT_ANY) || (req_q.opcode == OP_GRANT_POOL);
	assign last_pool = (32'(pool_q) == NUM_POOLS - 1);
	assign out_free  = !out_valid_q || out_ready;

	// bits past the end of the pool's range count as taken
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			mask[b] = (word_q != pi.last_word) || (BIT_W'(b) <= pi.last_bit);
		end
		free_bits = ~ram_rdata & mask;
		low_bit   = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				low_bit = BIT_W'(b);
			end
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign lookup_addr = req_q.req_address;
	assign ram_raddr   = ram_addr(pool_q, word_q);

	always_comb begin
		ram_wr = '0;
		if (state_q == S_CLEAR) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = clr_q;
		end else if (state_q == S_WRITE) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = ram_addr(pool_q, word_q);
			ram_wr.data = wdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			req_q       <= '0;
			pool_q      <= '0;
			word_q      <= '0;
			bit_q       <= '0;
			wdata_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(RAM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						res_q   <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (req_q.opcode)
						OP_GRANT_ANY: begin
							pool_q  <= '0;
							state_q <= S_PSEL;
						end
						OP_GRANT_POOL: begin
							if (32'(req_q.pool_select) < NUM_POOLS) begin
								pool_q  <= POOL_W'(req_q.pool_select);
								state_q <= S_PSEL;
							end else begin
								res_q.status <= ST_NO_POOL;
								state_q      <= S_FINISH;
							end
						end
						OP_CLAIM, OP_RELEASE, OP_QUERY: begin
							if (owner.hit) begin
								pool_q  <= owner.pool;
								word_q  <= owner.word;
								bit_q   <= owner.bit_sel;
								state_q <= S_READ;
							end else begin
								res_q.status <= ST_NO_POOL;
								state_q      <= S_FINISH;
							end
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_PSEL: begin
					if (pi.exists) begin
						word_q  <= '0;
						state_q <= S_READ;
					end else if (req_q.opcode == OP_GRANT_POOL) begin
						res_q.status <= ST_NO_POOL;
						state_q      <= S_FINISH;
					end else if (last_pool) begin
						res_q.status <= ST_DEPLETED;
						state_q      <= S_FINISH;
					end else begin
						pool_q <= pool_q + 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (is_grant) begin
						if (|free_bits) begin
							wdata_q <= ram_rdata | (WORD_W'(1) << low_bit);
							res_q.granted_address <= pi.first +
								ADDR_FIELD_W'({word_q, low_bit});
							state_q <= S_WRITE;
						end else if (word_q != pi.last_word) begin
							word_q  <= word_q + 1'b1;
							state_q <= S_READ;
						end else if (req_q.opcode == OP_GRANT_ANY && !last_pool) begin
							// this pool is full, move on to the next one
							pool_q  <= pool_q + 1'b1;
							state_q <= S_PSEL;
						end else begin
							res_q.status <= ST_DEPLETED;
							state_q      <= S_FINISH;
						end
					end else if (req_q.opcode == OP_CLAIM) begin
						if (ram_rdata[bit_q]) begin
							res_q.status <= ST_IN_USE;
							state_q      <= S_FINISH;
						end else begin
							wdata_q <= ram_rdata | (WORD_W'(1) << bit_q);
							res_q.granted_address <= req_q.req_address;
							state_q <= S_WRITE;
						end
					end else if (req_q.opcode == OP_RELEASE) begin
						if (!ram_rdata[bit_q]) begin
							res_q.status <= ST_NOT_IN_USE;
							state_q      <= S_FINISH;
						end else begin
							wdata_q <= ram_rdata & ~(WORD_W'(1) << bit_q);
							state_q <= S_WRITE;
						end
					end else begin
						res_q.is_free <= !ram_rdata[bit_q];
						state_q       <= S_FINISH;
					end
				end
				S_WRITE: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
